// ----- sv/jdcal_pkg.sv -----
// jdcal_pkg: shared types, widths and constants for the julian date converter
// used by every module of the converter; depends on nothing
`default_nettype none

package jdcal_pkg;

    // field widths
    localparam int FRAC_W   = 32;
    localparam int WHOLE_W  = 31;
    localparam int YEAR_W   = 24;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    // pipeline depth, one valid bit per stage
    localparam int NSTAGES = 9;

    // day number chain constants
    localparam longint unsigned L0_OFFSET    = 68569;
    localparam longint unsigned N_MUL        = 4;
    localparam longint unsigned N_DIV        = 146097;
    localparam longint unsigned I_MUL        = 4000;
    localparam longint unsigned I_DIV        = 1461001;
    localparam longint unsigned L2_MUL       = 1461;
    localparam longint unsigned L2_OFFSET    = 31;
    localparam longint unsigned J_MUL        = 80;
    localparam longint unsigned J_DIV        = 2447;
    localparam longint unsigned YEAR_SCALE   = 100;
    localparam longint unsigned CENTURY_BIAS = 49;
    localparam longint unsigned MONTH_WRAP   = 11;
    localparam longint unsigned MONTH_SPAN   = 12;
    localparam longint unsigned MONTH_BASE   = 2;

    // time of day scale factors
    localparam longint unsigned HOURS_PER_DAY   = 24;
    localparam longint unsigned SIXTY           = 60;

    // reciprocal estimates: q_est = floor(y * R / 2^S), R = floor(K * 2^S / D),
    // S no smaller than the width of y, so q_est is q or q - 1
    localparam int N_SHIFT = 32;
    localparam int I_SHIFT = 16;
    localparam int J_SHIFT = 9;
    localparam logic [16:0] N_RECIP = 17'((N_MUL << N_SHIFT) / N_DIV);
    localparam logic [7:0]  I_RECIP = 8'((I_MUL << I_SHIFT) / I_DIV);
    localparam logic [4:0]  J_RECIP = 5'((J_MUL << J_SHIFT) / J_DIV);

    // status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_TOO_BIG = 1'b1;

    typedef struct packed {
        logic [WHOLE_W-1:0] julian_whole;
        logic [FRAC_W-1:0]  julian_fraction;
    } jd_item_t;

    typedef struct packed {
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
        logic [HOUR_W-1:0]        hour;
        logic [MINUTE_W-1:0]      minute;
        logic [SECOND_W-1:0]      second_whole;
        logic [FRAC_W-1:0]        second_fraction;
        logic                     status;
    } cal_item_t;

    // per-stage load enables from the pipeline control
    typedef struct packed {
        logic [NSTAGES-1:0] load;
    } stage_ctl_t;

    typedef struct packed {
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
        logic                     err;
    } date_t;

    // rest holds the running remainder until the last split, then the
    // fraction of a second
    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second_whole;
        logic [FRAC_W-1:0]   rest;
    } tod_t;

    // floor(2447 * j / 80): day offset of the start of month slot j
    function automatic logic [8:0] month_start(input logic [3:0] j);
        logic [8:0] r;
        case (j)
            4'd0:  r = 9'd0;
            4'd1:  r = 9'd30;
            4'd2:  r = 9'd61;
            4'd3:  r = 9'd91;
            4'd4:  r = 9'd122;
            4'd5:  r = 9'd152;
            4'd6:  r = 9'd183;
            4'd7:  r = 9'd214;
            4'd8:  r = 9'd244;
            4'd9:  r = 9'd275;
            4'd10: r = 9'd305;
            4'd11: r = 9'd336;
            4'd12: r = 9'd367;
            4'd13: r = 9'd397;
            4'd14: r = 9'd428;
            4'd15: r = 9'd458;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/julian_date_to_calendar.sv -----
// julian date to gregorian calendar date and time of day, nine-stage pipeline
// throughput: one item per cycle unless the output stalls; the nine stage registers with their valid bits set it
// a stalled output holds its item; empty stages keep filling behind it
// reset: rst_n clears all valid bits at once, no clearing pass; payload is not reset
// depends on jdcal_pkg, jdcal_ctrl, jdcal_date, jdcal_tod
`default_nettype none

module julian_date_to_calendar (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                jd_valid,
    output logic                     jd_ready,
    input  wire jdcal_pkg::jd_item_t jd,
    output logic                     cal_valid,
    input  wire logic                cal_ready,
    output jdcal_pkg::cal_item_t     cal
);
    import jdcal_pkg::*;

    stage_ctl_t ctl;
    date_t      date;
    tod_t       tod;

    // stage valid bits and the stall chain; a stage loads a valid upstream item when it is empty
    // or its item moves on in the same cycle
    jdcal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .jd_valid  (jd_valid),
        .jd_ready  (jd_ready),
        .cal_valid (cal_valid),
        .cal_ready (cal_ready),
        .ctl       (ctl)
    );

    // fliegel-van flandern chain: the divisions for n, i and j are each a reciprocal
    // estimate in one stage and a single-step correction in the next
    jdcal_date u_date (
        .clk  (clk),
        .ctl  (ctl),
        .jd   (jd),
        .date (date)
    );

    // exact truncating split of the day fraction, delayed to line up with the date
    jdcal_tod u_tod (
        .clk (clk),
        .ctl (ctl),
        .jd  (jd),
        .tod (tod)
    );

    // day number past the 31-bit limit: status set, every other field zero
    always_comb
    begin
        cal = '0;
        if (date.err)
        begin
            cal.status = STATUS_TOO_BIG;
        end
        else
        begin
            cal.year            = date.year;
            cal.month           = date.month;
            cal.day             = date.day;
            cal.hour            = tod.hour;
            cal.minute          = tod.minute;
            cal.second_whole    = tod.second_whole;
            cal.second_fraction = tod.rest;
            cal.status          = STATUS_OK;
        end
    end

`ifndef SYNTHESIS
    // a free output side never stalls the input
    assert property (@(posedge clk) disable iff (!rst_n)
        cal_ready |-> jd_ready)
        else $error("input stalled while output side is free");

    // a good result is a real calendar date and time of day
    assert property (@(posedge clk) disable iff (!rst_n)
        cal_valid && cal.status == STATUS_OK |->
            cal.month >= 4'd1 && cal.month <= 4'd12 && cal.day >= 5'd1
            && cal.hour <= 5'd23 && cal.minute <= 6'd59 && cal.second_whole <= 6'd59)
        else $error("calendar field out of range");

    // short months never run past their length
    assert property (@(posedge clk) disable iff (!rst_n)
        cal_valid && cal.status == STATUS_OK |->
            !(cal.month == 4'd2 && cal.day > 5'd29)
            && !((cal.month == 4'd4 || cal.month == 4'd6 || cal.month == 4'd9
                  || cal.month == 4'd11) && cal.day > 5'd30))
        else $error("day past end of month");
`endif

endmodule

`default_nettype wire

// ----- sv/jdcal_ctrl.sv -----
// jdcal_ctrl: valid bits and stall control for the nine converter stages
// depends on jdcal_pkg
`default_nettype none

module jdcal_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    jd_valid,
    output logic                         jd_ready,
    output logic                         cal_valid,
    input  wire logic                    cal_ready,
    output jdcal_pkg::stage_ctl_t        ctl
);
    import jdcal_pkg::*;

    logic [NSTAGES-1:0] valid_reg;
    logic [NSTAGES-1:0] valid_next;
    logic [NSTAGES:0]   rdy;
    logic [NSTAGES-1:0] up_valid;

    // a stage can take an item when empty or when its item moves on
    always_comb
    begin
        rdy[NSTAGES] = cal_ready;
        for (int k = NSTAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        up_valid = {valid_reg[NSTAGES-2:0], jd_valid};
        for (int k = 0; k < NSTAGES; k++)
        begin
            valid_next[k] = rdy[k] ? up_valid[k] : valid_reg[k];
            ctl.load[k]   = rdy[k] && up_valid[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign jd_ready  = rdy[0];
    assign cal_valid = valid_reg[NSTAGES-1];

endmodule

`default_nettype wire

// ----- sv/jdcal_date.sv -----
// jdcal_date: day number to gregorian year, month and day, nine stages
// depends on jdcal_pkg; load enables come from jdcal_ctrl
`default_nettype none

module jdcal_date (
    input  wire logic                 clk,
    input  wire jdcal_pkg::stage_ctl_t ctl,
    input  wire jdcal_pkg::jd_item_t  jd,
    output jdcal_pkg::date_t          date
);
    import jdcal_pkg::*;

    // stage 0: half-day carry, range check, offset
    logic [WHOLE_W:0] dayno;
    logic [31:0]      s0_l0_reg;
    logic             s0_err_reg;

    // stage 1: estimate of n
    logic [48:0]      n_prod;
    logic [31:0]      s1_l0_reg;
    logic [16:0]      s1_nest_reg;
    logic             s1_err_reg;

    // stage 2: correct n, l1 from the remainder
    logic [33:0]      a0;
    logic [33:0]      a_fix;
    logic             n_ge;
    logic [16:0]      s2_n_reg;
    logic [15:0]      s2_l1_reg;
    logic             s2_err_reg;

    // stage 3: estimate of i, century part of the year
    logic [24:0]      i_prod;
    logic [15:0]      s3_l1_reg;
    logic [6:0]       s3_iest_reg;
    logic [YEAR_W-1:0] s3_y_reg;
    logic             s3_err_reg;

    // stage 4: correct i
    logic [16:0]      l1p1;
    logic [27:0]      i_rem;
    logic             i_ge;
    logic [15:0]      s4_l1_reg;
    logic [6:0]       s4_i_reg;
    logic [YEAR_W-1:0] s4_y_reg;
    logic             s4_err_reg;

    // stage 5: day of the march-based year
    logic [17:0]      l2_w;
    logic [8:0]       s5_l2_reg;
    logic [YEAR_W-1:0] s5_y_reg;
    logic             s5_err_reg;

    // stage 6: estimate of j
    logic [13:0]      j_prod;
    logic [8:0]       s6_l2_reg;
    logic [3:0]       s6_jest_reg;
    logic [YEAR_W-1:0] s6_y_reg;
    logic             s6_err_reg;

    // stage 7: correct j
    logic [15:0]      j_rem;
    logic             j_ge;
    logic [8:0]       s7_l2_reg;
    logic [3:0]       s7_j_reg;
    logic [YEAR_W-1:0] s7_y_reg;
    logic             s7_err_reg;

    // stage 8: day, month, year
    logic [8:0]       d_w;
    logic             wrap;
    date_t            date_next;
    date_t            date_reg;

    assign dayno = {1'b0, jd.julian_whole} + (WHOLE_W+1)'(jd.julian_fraction[FRAC_W-1]);

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            s0_l0_reg  <= 32'(dayno) + 32'(L0_OFFSET);
            s0_err_reg <= dayno[WHOLE_W];
        end
    end

    assign n_prod = 49'(s0_l0_reg) * 49'(N_RECIP);

    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            s1_l0_reg   <= s0_l0_reg;
            s1_nest_reg <= n_prod[48:32];
            s1_err_reg  <= s0_err_reg;
        end
    end

    // remainder of 4 l0 by 146097; l1 is a quarter of it
    assign a0    = {s1_l0_reg, 2'b00} - 34'(34'(s1_nest_reg) * 34'(N_DIV));
    assign n_ge  = a0 >= 34'(N_DIV);
    assign a_fix = n_ge ? a0 - 34'(N_DIV) : a0;

    always_ff @(posedge clk)
    begin
        if (ctl.load[2])
        begin
            s2_n_reg   <= s1_nest_reg + 17'(n_ge);
            s2_l1_reg  <= a_fix[17:2];
            s2_err_reg <= s1_err_reg;
        end
    end

    assign i_prod = 25'(17'(s2_l1_reg) + 17'd1) * 25'(I_RECIP);

    always_ff @(posedge clk)
    begin
        if (ctl.load[3])
        begin
            s3_l1_reg   <= s2_l1_reg;
            s3_iest_reg <= i_prod[I_SHIFT+6:I_SHIFT];
            s3_y_reg    <= YEAR_W'(YEAR_W'(s2_n_reg) * YEAR_W'(YEAR_SCALE))
                           - YEAR_W'(YEAR_SCALE * CENTURY_BIAS);
            s3_err_reg  <= s2_err_reg;
        end
    end

    assign l1p1  = 17'(s3_l1_reg) + 17'd1;
    assign i_rem = 28'(28'(l1p1) * 28'(I_MUL)) - 28'(28'(s3_iest_reg) * 28'(I_DIV));
    assign i_ge  = i_rem >= 28'(I_DIV);

    always_ff @(posedge clk)
    begin
        if (ctl.load[4])
        begin
            s4_l1_reg  <= s3_l1_reg;
            s4_i_reg   <= s3_iest_reg + 7'(i_ge);
            s4_y_reg   <= s3_y_reg;
            s4_err_reg <= s3_err_reg;
        end
    end

    assign l2_w = 18'(s4_l1_reg) + 18'(L2_OFFSET)
                  - (18'(18'(s4_i_reg) * 18'(L2_MUL)) >> 2);

    always_ff @(posedge clk)
    begin
        if (ctl.load[5])
        begin
            s5_l2_reg  <= l2_w[8:0];
            s5_y_reg   <= s4_y_reg + YEAR_W'(s4_i_reg);
            s5_err_reg <= s4_err_reg;
        end
    end

    assign j_prod = 14'(s5_l2_reg) * 14'(J_RECIP);

    always_ff @(posedge clk)
    begin
        if (ctl.load[6])
        begin
            s6_l2_reg   <= s5_l2_reg;
            s6_jest_reg <= j_prod[J_SHIFT+3:J_SHIFT];
            s6_y_reg    <= s5_y_reg;
            s6_err_reg  <= s5_err_reg;
        end
    end

    assign j_rem = 16'(16'(s6_l2_reg) * 16'(J_MUL)) - 16'(16'(s6_jest_reg) * 16'(J_DIV));
    assign j_ge  = j_rem >= 16'(J_DIV);

    always_ff @(posedge clk)
    begin
        if (ctl.load[7])
        begin
            s7_l2_reg  <= s6_l2_reg;
            s7_j_reg   <= s6_jest_reg + 4'(j_ge);
            s7_y_reg   <= s6_y_reg;
            s7_err_reg <= s6_err_reg;
        end
    end

    // month slots 11 and up are january and february of the next year
    assign d_w  = s7_l2_reg - month_start(s7_j_reg);
    assign wrap = s7_j_reg >= 4'(MONTH_WRAP);

    always_comb
    begin
        date_next.year  = s7_y_reg + YEAR_W'(wrap);
        date_next.month = s7_j_reg + 4'(MONTH_BASE) - (wrap ? 4'(MONTH_SPAN) : 4'd0);
        date_next.day   = d_w[DAY_W-1:0];
        date_next.err   = s7_err_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[8])
        begin
            date_reg <= date_next;
        end
    end

    assign date = date_reg;

endmodule

`default_nettype wire

// ----- sv/jdcal_tod.sv -----
// jdcal_tod: split of the day fraction into hour, minute and seconds,
// three working stages then a delay line; depends on jdcal_pkg
`default_nettype none

module jdcal_tod (
    input  wire logic                  clk,
    input  wire jdcal_pkg::stage_ctl_t ctl,
    input  wire jdcal_pkg::jd_item_t   jd,
    output jdcal_pkg::tod_t            tod
);
    import jdcal_pkg::*;

    logic [FRAC_W-1:0]   frac;
    logic [FRAC_W+4:0]   hr_prod;
    logic [FRAC_W+5:0]   mn_prod;
    logic [FRAC_W+5:0]   sc_prod;
    tod_t                tod_next [NSTAGES];
    tod_t                tod_reg  [NSTAGES];

    // adding half a day flips the top fraction bit; the carry goes to the date
    assign frac    = {~jd.julian_fraction[FRAC_W-1], jd.julian_fraction[FRAC_W-2:0]};
    assign hr_prod = (FRAC_W+5)'(frac) * (FRAC_W+5)'(HOURS_PER_DAY);
    assign mn_prod = (FRAC_W+6)'(tod_reg[0].rest) * (FRAC_W+6)'(SIXTY);
    assign sc_prod = (FRAC_W+6)'(tod_reg[1].rest) * (FRAC_W+6)'(SIXTY);

    always_comb
    begin
        tod_next[0]              = '0;
        tod_next[0].hour         = hr_prod[FRAC_W+4:FRAC_W];
        tod_next[0].rest         = hr_prod[FRAC_W-1:0];

        tod_next[1]              = tod_reg[0];
        tod_next[1].minute       = mn_prod[FRAC_W+5:FRAC_W];
        tod_next[1].rest         = mn_prod[FRAC_W-1:0];

        tod_next[2]              = tod_reg[1];
        tod_next[2].second_whole = sc_prod[FRAC_W+5:FRAC_W];
        tod_next[2].rest         = sc_prod[FRAC_W-1:0];

        for (int k = 3; k < NSTAGES; k++)
        begin
            tod_next[k] = tod_reg[k-1];
        end
    end

    for (genvar k = 0; k < NSTAGES; k++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (ctl.load[k])
            begin
                tod_reg[k] <= tod_next[k];
            end
        end
    end

    assign tod = tod_reg[NSTAGES-1];

endmodule

`default_nettype wire
